### hw/rtl/msq_pkg.sv
// Shared types, constants and tables of the music sequence command decoder.
// No dependencies; the classifier, queue, executor and top level import this package.
`default_nettype none

package msq_pkg;

    // Default depth of the queue between the classifier and the executor.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENGINE_VERSION   = 2'd0,
        CFG_LENGTH_SHIFT     = 2'd1,
        CFG_VELOCITY_DEFAULT = 2'd2,
        CFG_TRACK_BASE       = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]  engine_version;
        logic [1:0]  length_shift;
        logic        velocity_default;
        logic [15:0] track_base;
    } t_cfg;

    localparam logic [1:0]  ENGINE_VERSION_RST   = 2'd2;
    localparam logic [1:0]  LENGTH_SHIFT_RST     = 2'd0;
    localparam logic        VELOCITY_DEFAULT_RST = 1'b0;
    localparam logic [15:0] TRACK_BASE_RST       = 16'h0000;

    // Running state after reset.
    localparam logic [7:0]  OCTAVE_RST = 8'd2;

    // Result codes.
    localparam logic [1:0] KIND_NOTE    = 2'd0;
    localparam logic [1:0] KIND_REST    = 2'd1;
    localparam logic [1:0] KIND_COMMAND = 2'd2;

    localparam logic [2:0] FLOW_NONE         = 3'd0;
    localparam logic [2:0] FLOW_REPEAT_START = 3'd1;
    localparam logic [2:0] FLOW_REPEAT_END   = 3'd2;
    localparam logic [2:0] FLOW_CALL         = 3'd3;
    localparam logic [2:0] FLOW_JUMP         = 3'd4;
    localparam logic [2:0] FLOW_RETURN       = 3'd5;

    // Opcode bytes.
    localparam logic [7:0] OPC_CMD_BASE   = 8'hD0;
    localparam logic [7:0] OPC_OCT_SET    = 8'hD2;
    localparam logic [7:0] OPC_OCT_UP     = 8'hD3;
    localparam logic [7:0] OPC_OCT_DOWN   = 8'hD4;
    localparam logic [7:0] OPC_V2_ONE_A   = 8'hD7;
    localparam logic [7:0] OPC_V2_ONE_B   = 8'hD8;
    localparam logic [7:0] OPC_REP_START  = 8'hDD;
    localparam logic [7:0] OPC_REP_END    = 8'hDE;
    localparam logic [7:0] OPC_CALL       = 8'hDF;
    localparam logic [7:0] OPC_JUMP       = 8'hE0;
    localparam logic [7:0] OPC_V2_FOUR    = 8'hE2;
    localparam logic [7:0] OPC_TR_SET     = 8'hE7;
    localparam logic [7:0] OPC_TR_ADD     = 8'hE8;
    localparam logic [7:0] OPC_LOOP_SET   = 8'hEB;
    localparam logic [7:0] OPC_LOOP_JUMP  = 8'hEC;
    localparam logic [7:0] OPC_LOOP_ONCE  = 8'hED;
    localparam logic [7:0] OPC_V2_ONE_C   = 8'hEE;
    localparam logic [7:0] OPC_V2_TWO_A   = 8'hF2;
    localparam logic [7:0] OPC_V2_TWO_B   = 8'hF3;
    localparam logic [7:0] OPC_EXT        = 8'hFE;
    localparam logic [7:0] OPC_RETURN     = 8'hFF;

    // Sub-command bytes of the extended command.
    localparam logic [7:0] SUB_PLAIN_LAST = 8'h09;
    localparam logic [7:0] SUB_VEL_OFF    = 8'h0C;
    localparam logic [7:0] SUB_ONE_ARG    = 8'h0D;
    localparam logic [7:0] SUB_TWO_FIRST  = 8'h10;
    localparam logic [7:0] SUB_JUMP_A     = 8'h15;
    localparam logic [7:0] SUB_JUMP_B     = 8'h17;
    localparam logic [7:0] SUB_JUMP_C     = 8'h19;
    localparam logic [7:0] SUB_TWO_LAST   = 8'h19;
    localparam logic [7:0] SUB_ONE_FIRST  = 8'h1A;
    localparam logic [7:0] SUB_ONE_LAST   = 8'h1E;

    // Note length table in ticks.
    localparam logic [7:0] LEN_TABLE [8] = '{
        8'hC0, 8'h60, 8'h30, 8'h18, 8'h0C, 8'h06, 8'h03, 8'h01
    };

    // Command sizes in bytes, indexed by opcode minus 0xD0.
    localparam int CMD_COUNT = 48;
    localparam logic [2:0] CMD_SIZE [CMD_COUNT] = '{
        3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd3,
        3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd1, 3'd2,
        3'd2, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3,
        3'd2, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1
    };

    // Operation classes handed from the classifier to the executor.
    typedef enum logic [4:0] {
        OP_NOTE,
        OP_REST,
        OP_OCT_SET,
        OP_OCT_UP,
        OP_OCT_DOWN,
        OP_REP_START,
        OP_REP_END,
        OP_CALL,
        OP_JUMP,
        OP_TR_SET,
        OP_TR_ADD,
        OP_LOOP_SET,
        OP_LOOP_ONCE,
        OP_LOOP_JUMP,
        OP_VEL_OFF,
        OP_SUB_JUMP,
        OP_RETURN,
        OP_OTHER
    } t_op;

    // One classified item. For notes and rests, bytes excludes the velocity byte.
    typedef struct packed {
        t_op         op;
        logic [2:0]  bytes;
        logic [7:0]  duration;
        logic [3:0]  key;
        logic [7:0]  arg;
        logic [15:0] target;
        logic [8:0]  count;
    } t_entry;

endpackage

`default_nettype wire

### hw/rtl/msq_in_if.sv
// Input channel of the decoder: valid/ready handshake and the event window.
// Stands alone; used by the top level and the classifier.
`default_nettype none

interface msq_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  opcode_byte;
    logic [7:0]  arg_one;
    logic [7:0]  arg_two;
    logic [7:0]  arg_three;
    logic [15:0] event_addr;

    modport source (
        output valid, opcode_byte, arg_one, arg_two, arg_three, event_addr,
        input  ready
    );
    modport sink (
        input  valid, opcode_byte, arg_one, arg_two, arg_three, event_addr,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/msq_out_if.sv
// Output channel of the decoder: valid/ready handshake and the decoded event.
// Stands alone; used by the top level and the executor.
`default_nettype none

interface msq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [2:0]         event_bytes;
    logic               pitch_valid;
    logic signed [12:0] pitch;
    logic [7:0]         duration;
    logic [2:0]         flow_kind;
    logic [15:0]        flow_target;
    logic [8:0]         flow_count;

    modport source (
        output valid, event_kind, event_bytes, pitch_valid, pitch, duration,
               flow_kind, flow_target, flow_count,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_bytes, pitch_valid, pitch, duration,
               flow_kind, flow_target, flow_count,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/msq_front.sv
// Classifier: decodes the opcode window into an operation class, size and length.
// Depends on msq_pkg and msq_in_if; feeds msq_queue.
`default_nettype none

module msq_front
    import msq_pkg::*;
(
    msq_in_if.sink   i_item,
    input  t_cfg     i_cfg,
    input  logic     i_full,
    output logic     o_push,
    output t_entry   o_entry
);

    logic [7:0] opc;
    logic [7:0] a1;
    logic [2:0] len_idx;
    logic [3:0] len_sum;
    logic [2:0] len_sel;
    logic [7:0] cmd_off;
    logic [1:0] sub_extra;
    logic       v2;

    assign opc = i_item.opcode_byte;
    assign a1  = i_item.arg_one;
    assign v2  = i_cfg.engine_version[1];

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    // Length table index: low bits minus one plus the song shift, capped at the last entry.
    assign len_idx = opc[2:0];
    assign len_sum = {1'b0, len_idx} + {2'b00, i_cfg.length_shift} - 4'd1;
    assign len_sel = len_sum[3] ? 3'd7 : len_sum[2:0];

    assign cmd_off = opc - OPC_CMD_BASE;

    // Extra argument bytes of an extended sub-command on newer engines.
    always_comb begin
        if (a1 <= SUB_PLAIN_LAST || !v2) begin
            sub_extra = 2'd0;
        end else if (a1 == SUB_ONE_ARG) begin
            sub_extra = 2'd1;
        end else if (a1 inside {[SUB_TWO_FIRST:SUB_TWO_LAST]}) begin
            sub_extra = 2'd2;
        end else if (a1 inside {[SUB_ONE_FIRST:SUB_ONE_LAST]}) begin
            sub_extra = 2'd1;
        end else begin
            sub_extra = 2'd0;
        end
    end

    always_comb begin
        o_entry          = '0;
        o_entry.op       = OP_OTHER;
        o_entry.key      = opc[7:4];
        o_entry.arg      = a1;
        if (opc < OPC_CMD_BASE) begin
            o_entry.op = (opc[7:4] != 4'd0) ? OP_NOTE : OP_REST;
            if (len_idx == 3'd0) begin
                o_entry.duration = a1;
                o_entry.bytes    = 3'd2;
            end else begin
                o_entry.duration = LEN_TABLE[len_sel];
                o_entry.bytes    = 3'd1;
            end
        end else begin
            // Command size.
            if (opc == OPC_EXT) begin
                o_entry.bytes = 3'd2 + {1'b0, sub_extra};
            end else if (v2 && (opc inside {OPC_V2_ONE_A, OPC_V2_ONE_B, OPC_V2_ONE_C})) begin
                o_entry.bytes = 3'd1;
            end else if (v2 && opc == OPC_V2_FOUR) begin
                o_entry.bytes = 3'd4;
            end else if (v2 && (opc inside {OPC_V2_TWO_A, OPC_V2_TWO_B})) begin
                o_entry.bytes = 3'd2;
            end else begin
                o_entry.bytes = CMD_SIZE[cmd_off[5:0]];
            end

            // Command class and the arguments it carries.
            case (opc)
                OPC_OCT_SET:   o_entry.op = OP_OCT_SET;
                OPC_OCT_UP:    o_entry.op = OP_OCT_UP;
                OPC_OCT_DOWN:  o_entry.op = OP_OCT_DOWN;
                OPC_REP_START: begin
                    o_entry.op    = OP_REP_START;
                    o_entry.count = {a1 == 8'd0, a1};
                end
                OPC_REP_END:   o_entry.op = OP_REP_END;
                OPC_CALL: begin
                    o_entry.op     = OP_CALL;
                    o_entry.target = {i_item.arg_two, a1};
                    o_entry.count  = 9'd1;
                end
                OPC_JUMP: begin
                    o_entry.op     = OP_JUMP;
                    o_entry.target = {i_item.arg_two, a1};
                end
                OPC_TR_SET:    o_entry.op = OP_TR_SET;
                OPC_TR_ADD:    o_entry.op = OP_TR_ADD;
                OPC_LOOP_SET: begin
                    o_entry.op     = OP_LOOP_SET;
                    o_entry.target = i_item.event_addr + 16'd1;
                end
                OPC_LOOP_ONCE: begin
                    o_entry.op     = OP_LOOP_ONCE;
                    o_entry.target = i_item.event_addr + 16'd1;
                end
                OPC_LOOP_JUMP: o_entry.op = OP_LOOP_JUMP;
                OPC_EXT: begin
                    if (a1 == SUB_VEL_OFF) begin
                        o_entry.op = OP_VEL_OFF;
                    end else if (a1 inside {SUB_JUMP_A, SUB_JUMP_B, SUB_JUMP_C}) begin
                        o_entry.op     = OP_SUB_JUMP;
                        o_entry.target = {i_item.arg_three, i_item.arg_two};
                        o_entry.count  = 9'd1;
                    end else begin
                        o_entry.op = OP_OTHER;
                    end
                end
                OPC_RETURN:    o_entry.op = OP_RETURN;
                default:       o_entry.op = OP_OTHER;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/msq_queue.sv
// Small first-in first-out queue of classified items between classifier and executor.
// Depends on msq_pkg for the item type.
`default_nettype none

module msq_queue
    import msq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty,
    output logic   o_full
);

    localparam int AW = $clog2(DEPTH);

    t_entry            r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic [AW-1:0]     n_wr_ptr;
    logic [AW-1:0]     n_rd_ptr;
    logic [AW:0]       n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    // Pointers wrap naturally since the depth is a power of two.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + (AW+1)'(1)))
        else $error("queue occupancy did not follow a write");
`endif

endmodule

`default_nettype wire

### hw/rtl/msq_back.sv
// Executor: applies classified items to the running sequence state and
// registers the decoded event. Depends on msq_pkg and msq_out_if.
`default_nettype none

module msq_back
    import msq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_entry    i_entry,
    input  logic      i_empty,
    output logic      o_pop,
    msq_out_if.source o_item
);

    // Running state.
    logic [7:0]  r_octave;
    logic [7:0]  r_transpose;
    logic [15:0] r_loop_point;
    logic        r_loop_once_taken;
    logic        r_vel_forced_off;
    logic [7:0]  n_octave;
    logic [7:0]  n_transpose;
    logic [15:0] n_loop_point;
    logic        n_loop_once_taken;
    logic        n_vel_forced_off;

    // Output register.
    logic               r_out_valid;
    logic [1:0]         r_event_kind;
    logic [2:0]         r_event_bytes;
    logic               r_pitch_valid;
    logic signed [12:0] r_pitch;
    logic [7:0]         r_duration;
    logic [2:0]         r_flow_kind;
    logic [15:0]        r_flow_target;
    logic [8:0]         r_flow_count;

    logic [1:0]         n_event_kind;
    logic [2:0]         n_event_bytes;
    logic               n_pitch_valid;
    logic signed [12:0] n_pitch;
    logic [7:0]         n_duration;
    logic [2:0]         n_flow_kind;
    logic [15:0]        n_flow_target;
    logic [8:0]         n_flow_count;

    logic [11:0]        oct12;
    logic signed [12:0] note_pitch;
    logic               vel_byte;
    logic               is_pitched;

    assign o_pop = !i_empty && (!r_out_valid || o_item.ready);

    assign oct12 = {1'b0, r_octave, 3'b000} + {2'b00, r_octave, 2'b00};
    assign note_pitch = $signed({1'b0, oct12}) + $signed({9'b0, i_entry.key})
                      + $signed({{5{r_transpose[7]}}, r_transpose}) - 13'sd13;

    assign is_pitched = (i_entry.op == OP_NOTE) || (i_entry.op == OP_REST);
    assign vel_byte   = is_pitched && i_cfg.velocity_default && !r_vel_forced_off;

    always_comb begin
        n_octave          = r_octave;
        n_transpose       = r_transpose;
        n_loop_point      = r_loop_point;
        n_loop_once_taken = r_loop_once_taken;
        n_vel_forced_off  = r_vel_forced_off;

        n_event_kind  = KIND_COMMAND;
        n_event_bytes = i_entry.bytes + {2'b00, vel_byte};
        n_pitch_valid = 1'b0;
        n_pitch       = '0;
        n_duration    = '0;
        n_flow_kind   = FLOW_NONE;
        n_flow_target = '0;
        n_flow_count  = '0;

        case (i_entry.op)
            OP_NOTE: begin
                n_event_kind  = KIND_NOTE;
                n_pitch_valid = 1'b1;
                n_pitch       = note_pitch;
                n_duration    = i_entry.duration;
            end
            OP_REST: begin
                n_event_kind = KIND_REST;
                n_duration   = i_entry.duration;
            end
            OP_OCT_SET:  n_octave = i_entry.arg;
            OP_OCT_UP:   n_octave = r_octave + 8'd1;
            OP_OCT_DOWN: n_octave = r_octave - 8'd1;
            OP_REP_START: begin
                n_flow_kind  = FLOW_REPEAT_START;
                n_flow_count = i_entry.count;
            end
            OP_REP_END:  n_flow_kind = FLOW_REPEAT_END;
            OP_CALL: begin
                n_flow_kind   = FLOW_CALL;
                n_flow_target = i_entry.target;
                n_flow_count  = i_entry.count;
            end
            OP_JUMP, OP_SUB_JUMP: begin
                n_flow_kind   = FLOW_JUMP;
                n_flow_target = i_entry.target;
                n_flow_count  = i_entry.count;
            end
            OP_TR_SET:   n_transpose = i_entry.arg;
            OP_TR_ADD:   n_transpose = r_transpose + i_entry.arg;
            OP_LOOP_SET: n_loop_point = i_entry.target;
            OP_LOOP_ONCE: begin
                if (!r_loop_once_taken) begin
                    n_loop_point      = i_entry.target;
                    n_loop_once_taken = 1'b1;
                end
            end
            OP_LOOP_JUMP: begin
                // A zero loop point means none was set: fall back to the track start.
                n_flow_kind   = FLOW_JUMP;
                n_flow_target = (r_loop_point != 16'd0) ? r_loop_point : i_cfg.track_base;
            end
            OP_VEL_OFF:  n_vel_forced_off = 1'b1;
            OP_RETURN:   n_flow_kind = FLOW_RETURN;
            default:     ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave          <= OCTAVE_RST;
            r_transpose       <= '0;
            r_loop_point      <= '0;
            r_loop_once_taken <= 1'b0;
            r_vel_forced_off  <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (o_pop) begin
                r_octave          <= n_octave;
                r_transpose       <= n_transpose;
                r_loop_point      <= n_loop_point;
                r_loop_once_taken <= n_loop_once_taken;
                r_vel_forced_off  <= n_vel_forced_off;
                r_out_valid       <= 1'b1;
            end else if (o_item.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event_kind  <= n_event_kind;
            r_event_bytes <= n_event_bytes;
            r_pitch_valid <= n_pitch_valid;
            r_pitch       <= n_pitch;
            r_duration    <= n_duration;
            r_flow_kind   <= n_flow_kind;
            r_flow_target <= n_flow_target;
            r_flow_count  <= n_flow_count;
        end
    end

    assign o_item.valid       = r_out_valid;
    assign o_item.event_kind  = r_event_kind;
    assign o_item.event_bytes = r_event_bytes;
    assign o_item.pitch_valid = r_pitch_valid;
    assign o_item.pitch       = r_pitch;
    assign o_item.duration    = r_duration;
    assign o_item.flow_kind   = r_flow_kind;
    assign o_item.flow_target = r_flow_target;
    assign o_item.flow_count  = r_flow_count;

`ifndef SYNTHESIS
    a_vel_off_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_vel_forced_off) |-> r_vel_forced_off)
        else $error("forced velocity off cleared without reset");
    a_once_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_loop_once_taken) |-> r_loop_once_taken)
        else $error("first-pass flag cleared without reset");
    a_once_keeps_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.op == OP_LOOP_ONCE && r_loop_once_taken)
        |=> $stable(r_loop_point))
        else $error("loop point moved by a second first-pass marker");
`endif

endmodule

`default_nettype wire

### hw/rtl/music_sequence_command_decoder.sv
// Top level of the music sequence command decoder: configuration registers,
// classifier, item queue and executor. Depends on msq_pkg, both channel
// interfaces, msq_front, msq_queue and msq_back.
//
// The decoder takes one four-byte event window per cycle on i_item while its
// ready is high and returns one decoded event per accepted item on o_item, in
// order. Sustained rate is one item per clock while o_item does not stall. An
// item accepted at a clock edge is classified combinationally and written into
// the queue at that edge; the executor pops it once the output register is free
// and registers the result, raising o_item.valid. The executor holds the running
// octave, transpose, loop point and flags and applies one item per cycle while
// the output is free, which is what sets the rate. When o_item stalls, the queue
// (QUEUE_DEPTH items) plus the output register keep absorbing input until the
// queue fills, and i_item.ready then drops. The user must write configuration
// (i_cfg_we, i_cfg_index, i_cfg_wdata) only while the block is idle, unchecked
// by it; indexes: engine version, length shift, velocity default, track start.
`default_nettype none

module music_sequence_command_decoder
    import msq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    msq_in_if.sink                 i_item,
    msq_out_if.source              o_item
);

    t_cfg   r_cfg;
    t_entry front_entry;
    t_entry queue_entry;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;

    // Configuration registers; the narrow fields keep only the low bits of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.engine_version   <= ENGINE_VERSION_RST;
            r_cfg.length_shift     <= LENGTH_SHIFT_RST;
            r_cfg.velocity_default <= VELOCITY_DEFAULT_RST;
            r_cfg.track_base       <= TRACK_BASE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ENGINE_VERSION:   r_cfg.engine_version   <= i_cfg_wdata[1:0];
                CFG_LENGTH_SHIFT:     r_cfg.length_shift     <= i_cfg_wdata[1:0];
                CFG_VELOCITY_DEFAULT: r_cfg.velocity_default <= i_cfg_wdata[0];
                CFG_TRACK_BASE:       r_cfg.track_base       <= i_cfg_wdata[15:0];
                default:              ;
            endcase
        end
    end

    msq_front u_front (
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    msq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    msq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_entry (queue_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire
